[rtl/core/ell_pkg.sv]
// Package for the expression language lexer: token kinds, lexer modes,
// character codes and the token record type.
// Depends on nothing; used by expression_language_lexer.
`default_nettype none

package ell_pkg;

  // Token kinds as they appear on out_token_kind.
  localparam logic [4:0] K_INT    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_ASGN   = 5'd2;
  localparam logic [4:0] K_EQL    = 5'd3;
  localparam logic [4:0] K_OPEN   = 5'd4;
  localparam logic [4:0] K_CLOSE  = 5'd5;
  localparam logic [4:0] K_ADD    = 5'd6;
  localparam logic [4:0] K_SUB    = 5'd7;
  localparam logic [4:0] K_MUL    = 5'd8;
  localparam logic [4:0] K_DIV    = 5'd9;
  localparam logic [4:0] K_GT     = 5'd10;
  localparam logic [4:0] K_GTE    = 5'd11;
  localparam logic [4:0] K_LT     = 5'd12;
  localparam logic [4:0] K_LTE    = 5'd13;
  localparam logic [4:0] K_RET    = 5'd14;
  localparam logic [4:0] K_AND    = 5'd15;
  localparam logic [4:0] K_BWAND  = 5'd16;
  localparam logic [4:0] K_OR     = 5'd17;
  localparam logic [4:0] K_BWOR   = 5'd18;
  localparam logic [4:0] K_IF     = 5'd19;
  localparam logic [4:0] K_ELSE   = 5'd20;
  localparam logic [4:0] K_LOOP   = 5'd21;
  localparam logic [4:0] K_CALL   = 5'd22;
  localparam logic [4:0] K_FUNC   = 5'd23;
  localparam logic [4:0] K_ERROR  = 5'd24;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Lexer modes, one-hot.
  typedef enum logic [11:0] {
    MODE_IDLE    = 12'b0000_0000_0001,
    MODE_INT     = 12'b0000_0000_0010,
    MODE_IDENT   = 12'b0000_0000_0100,
    MODE_EQ      = 12'b0000_0000_1000,
    MODE_GT      = 12'b0000_0001_0000,
    MODE_LT      = 12'b0000_0010_0000,
    MODE_AMP     = 12'b0000_0100_0000,
    MODE_BAR     = 12'b0000_1000_0000,
    MODE_COLON   = 12'b0001_0000_0000,
    MODE_AT      = 12'b0010_0000_0000,
    MODE_SLASH   = 12'b0100_0000_0000,
    MODE_COMMENT = 12'b1000_0000_0000
  } mode_t;

  // One token record as it leaves the block.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       first;
    logic       last;
    logic       last_result;
  } rec_t;

  // Output queue geometry: room for two records per transfer plus slack.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

`default_nettype wire

[rtl/core/expression_language_lexer.sv]
// Top level of the expression language lexer: mode decode and token queue.
// Depends on ell_pkg.
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_ready     in_ch, in_end_of_input
// out       out_valid / out_ready   out_token_kind, out_text_char, out_piece_first,
//                                   out_piece_last, out_last_result
//
// One byte is taken per cycle while in_ready is high; its zero, one or two
// token records are decoded in the same cycle and written into a four-entry
// output queue. in_ready is high while the queue has room for two records,
// so the input stalls only when the output side falls behind. Records leave
// at one per cycle while out_ready is high, from the queue head. Reset (rst_n
// low, synchronous) returns the mode to idle and empties the queue.
module expression_language_lexer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_token_kind,
  output logic [7:0]      out_text_char,
  output logic            out_piece_first,
  output logic            out_piece_last,
  output logic            out_last_result
);

  ell_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     held_r, held_nxt;
  logic           first_r, first_nxt;

  ell_pkg::rec_t  q_r [ell_pkg::QDEPTH];
  logic [ell_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ell_pkg::QAW:0]   cnt_r;

  logic           in_xfer, out_xfer;
  logic [1:0]     n_rec;
  ell_pkg::rec_t  rec0, rec1;

  // Flush of the current mode.
  logic           fl_v;
  ell_pkg::rec_t  fl_rec;
  // Byte lexed from idle.
  logic           st_v;
  ell_pkg::rec_t  st_rec;
  ell_pkg::mode_t st_mode;
  logic [7:0]     st_held;
  logic           st_first;
  // Two-character completion.
  logic           pair_v;
  logic [4:0]     pair_kind;

  assign in_ready  = (cnt_r <= (ell_pkg::QAW+1)'(ell_pkg::QDEPTH - 2));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid && out_ready;

  // Record sent by the current mode when its token ends.
  always_comb begin
    fl_v   = 1'b1;
    fl_rec = '{kind: ell_pkg::K_ERROR, text: 8'd0, first: 1'b1, last: 1'b1,
               last_result: 1'b0};
    case (mode_r)
      ell_pkg::MODE_INT: begin
        fl_rec.kind  = ell_pkg::K_INT;
        fl_rec.text  = held_r;
        fl_rec.first = first_r;
      end
      ell_pkg::MODE_IDENT: begin
        fl_rec.kind  = ell_pkg::K_IDENT;
        fl_rec.text  = held_r;
        fl_rec.first = first_r;
      end
      ell_pkg::MODE_EQ:    fl_rec.kind = ell_pkg::K_ASGN;
      ell_pkg::MODE_GT:    fl_rec.kind = ell_pkg::K_GT;
      ell_pkg::MODE_LT:    fl_rec.kind = ell_pkg::K_LT;
      ell_pkg::MODE_AMP:   fl_rec.kind = ell_pkg::K_BWAND;
      ell_pkg::MODE_BAR:   fl_rec.kind = ell_pkg::K_BWOR;
      ell_pkg::MODE_COLON: fl_rec.text = ell_pkg::CH_COLON;
      ell_pkg::MODE_AT:    fl_rec.kind = ell_pkg::K_FUNC;
      ell_pkg::MODE_SLASH: fl_rec.kind = ell_pkg::K_DIV;
      default:             fl_v = 1'b0;
    endcase
  end

  // Lexing of the incoming byte from idle.
  always_comb begin
    st_v     = 1'b0;
    st_rec   = '{kind: ell_pkg::K_ERROR, text: 8'd0, first: 1'b1, last: 1'b1,
                 last_result: 1'b0};
    st_mode  = ell_pkg::MODE_IDLE;
    st_held  = 8'd0;
    st_first = 1'b0;
    if (ell_pkg::is_digit(in_ch) || ell_pkg::is_alpha(in_ch)) begin
      st_mode  = ell_pkg::is_digit(in_ch) ? ell_pkg::MODE_INT : ell_pkg::MODE_IDENT;
      st_held  = in_ch;
      st_first = 1'b1;
    end else begin
      case (in_ch)
        ell_pkg::CH_OPEN:  begin st_v = 1'b1; st_rec.kind = ell_pkg::K_OPEN;  end
        ell_pkg::CH_CLOSE: begin st_v = 1'b1; st_rec.kind = ell_pkg::K_CLOSE; end
        ell_pkg::CH_PLUS:  begin st_v = 1'b1; st_rec.kind = ell_pkg::K_ADD;   end
        ell_pkg::CH_MINUS: begin st_v = 1'b1; st_rec.kind = ell_pkg::K_SUB;   end
        ell_pkg::CH_STAR:  begin st_v = 1'b1; st_rec.kind = ell_pkg::K_MUL;   end
        ell_pkg::CH_QUEST: begin st_v = 1'b1; st_rec.kind = ell_pkg::K_IF;    end
        ell_pkg::CH_BANG:  begin st_v = 1'b1; st_rec.kind = ell_pkg::K_ELSE;  end
        ell_pkg::CH_EQ:    st_mode = ell_pkg::MODE_EQ;
        ell_pkg::CH_GT:    st_mode = ell_pkg::MODE_GT;
        ell_pkg::CH_LT:    st_mode = ell_pkg::MODE_LT;
        ell_pkg::CH_AMP:   st_mode = ell_pkg::MODE_AMP;
        ell_pkg::CH_BAR:   st_mode = ell_pkg::MODE_BAR;
        ell_pkg::CH_COLON: st_mode = ell_pkg::MODE_COLON;
        ell_pkg::CH_AT:    st_mode = ell_pkg::MODE_AT;
        ell_pkg::CH_SLASH: st_mode = ell_pkg::MODE_SLASH;
        ell_pkg::CH_SPACE, ell_pkg::CH_TAB, ell_pkg::CH_NEWLINE: st_v = 1'b0;
        default: begin
          // Unknown byte: error token carrying the byte.
          st_v        = 1'b1;
          st_rec.text = in_ch;
        end
      endcase
    end
  end

  // Two-character operator completion for the lookahead modes.
  always_comb begin
    pair_v    = 1'b0;
    pair_kind = ell_pkg::K_ERROR;
    case (mode_r)
      ell_pkg::MODE_EQ: begin
        pair_v = (in_ch == ell_pkg::CH_EQ);    pair_kind = ell_pkg::K_EQL;
      end
      ell_pkg::MODE_GT: begin
        pair_v = (in_ch == ell_pkg::CH_EQ);    pair_kind = ell_pkg::K_GTE;
      end
      ell_pkg::MODE_LT: begin
        pair_v    = (in_ch == ell_pkg::CH_MINUS) || (in_ch == ell_pkg::CH_EQ);
        pair_kind = (in_ch == ell_pkg::CH_MINUS) ? ell_pkg::K_RET : ell_pkg::K_LTE;
      end
      ell_pkg::MODE_AMP: begin
        pair_v = (in_ch == ell_pkg::CH_AMP);   pair_kind = ell_pkg::K_AND;
      end
      ell_pkg::MODE_BAR: begin
        pair_v = (in_ch == ell_pkg::CH_BAR);   pair_kind = ell_pkg::K_OR;
      end
      ell_pkg::MODE_COLON: begin
        pair_v = (in_ch == ell_pkg::CH_COLON); pair_kind = ell_pkg::K_LOOP;
      end
      ell_pkg::MODE_AT: begin
        pair_v = (in_ch == ell_pkg::CH_AT);    pair_kind = ell_pkg::K_CALL;
      end
      default: pair_v = 1'b0;
    endcase
  end

  // Mode update and assembly of the records caused by this byte.
  always_comb begin
    logic          use_flush;
    logic          use_start;
    logic          single_v;
    ell_pkg::rec_t single;
    use_flush = 1'b0;
    use_start = 1'b0;
    single_v  = 1'b0;
    single    = '{kind: pair_kind, text: 8'd0, first: 1'b1, last: 1'b1,
                  last_result: 1'b0};
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    first_nxt = first_r;

    if (in_end_of_input) begin
      use_flush = 1'b1;
      mode_nxt  = ell_pkg::MODE_IDLE;
      held_nxt  = 8'd0;
      first_nxt = 1'b0;
    end else begin
      case (mode_r)
        ell_pkg::MODE_INT, ell_pkg::MODE_IDENT: begin
          if (ell_pkg::is_digit(in_ch) ||
              ((mode_r == ell_pkg::MODE_IDENT) && ell_pkg::is_alpha(in_ch))) begin
            // Text continues: send the held character, hold the new one.
            single_v     = 1'b1;
            single.kind  = (mode_r == ell_pkg::MODE_INT) ? ell_pkg::K_INT
                                                         : ell_pkg::K_IDENT;
            single.text  = held_r;
            single.first = first_r;
            single.last  = 1'b0;
            held_nxt     = in_ch;
            first_nxt    = 1'b0;
          end else begin
            use_flush = 1'b1;
            use_start = 1'b1;
          end
        end
        ell_pkg::MODE_EQ, ell_pkg::MODE_GT, ell_pkg::MODE_LT, ell_pkg::MODE_AMP,
        ell_pkg::MODE_BAR, ell_pkg::MODE_COLON, ell_pkg::MODE_AT: begin
          if (pair_v) begin
            single_v = 1'b1;
            mode_nxt = ell_pkg::MODE_IDLE;
          end else begin
            use_flush = 1'b1;
            use_start = 1'b1;
          end
        end
        ell_pkg::MODE_SLASH: begin
          if (in_ch == ell_pkg::CH_SLASH) begin
            mode_nxt = ell_pkg::MODE_COMMENT;
          end else begin
            use_flush = 1'b1;
            use_start = 1'b1;
          end
        end
        ell_pkg::MODE_COMMENT: begin
          if (in_ch == ell_pkg::CH_NEWLINE) begin
            mode_nxt = ell_pkg::MODE_IDLE;
          end
        end
        default: use_start = 1'b1;
      endcase
    end

    if (use_start) begin
      mode_nxt  = st_mode;
      held_nxt  = st_held;
      first_nxt = st_first;
    end

    // Order the records: flushed token first, then the new byte's token.
    rec0  = single;
    rec1  = st_rec;
    n_rec = 2'd0;
    if (single_v) begin
      n_rec = 2'd1;
    end else if (use_flush && fl_v && use_start && st_v) begin
      rec0  = fl_rec;
      n_rec = 2'd2;
    end else if (use_flush && fl_v) begin
      rec0  = fl_rec;
      n_rec = 2'd1;
    end else if (use_start && st_v) begin
      rec0  = st_rec;
      n_rec = 2'd1;
    end

    if (n_rec == 2'd2) begin
      rec1.last_result = 1'b1;
    end else begin
      rec0.last_result = 1'b1;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ell_pkg::MODE_IDLE;
      held_r  <= 8'd0;
      first_r <= 1'b0;
    end else if (in_xfer) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      first_r <= first_nxt;
    end
  end

  // Output queue: up to two records written per input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer && (n_rec != 2'd0)) begin
      q_r[wr_ptr_r] <= rec0;
    end
    if (in_xfer && (n_rec == 2'd2)) begin
      q_r[wr_ptr_r + ell_pkg::QAW'(1)] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr_r <= wr_ptr_r + ell_pkg::QAW'(n_rec);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + ell_pkg::QAW'(1);
      end
      cnt_r <= cnt_r + (in_xfer ? (ell_pkg::QAW+1)'(n_rec) : '0)
                     - (out_xfer ? (ell_pkg::QAW+1)'(1) : '0);
    end
  end

  // Queue head drives the result ports.
  assign out_token_kind  = q_r[rd_ptr_r].kind;
  assign out_text_char   = q_r[rd_ptr_r].text;
  assign out_piece_first = q_r[rd_ptr_r].first;
  assign out_piece_last  = q_r[rd_ptr_r].last;
  assign out_last_result = q_r[rd_ptr_r].last_result;

endmodule

`default_nettype wire
